// ===== rtl/bfa_pkg.sv =====
package bfa_pkg;

  localparam int HEAP_PAGES  = 64;
  localparam int FREE_SLOTS  = 256;
  localparam int SLOT_AW     = $clog2(FREE_SLOTS);
  localparam int PAGE_CW     = $clog2(HEAP_PAGES + 1);
  localparam int STORE_DEPTH = HEAP_PAGES * 512;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int ADDR_W      = 18;
  localparam int SIZE_W      = 12;
  localparam int STAMP_W     = 32;
  localparam int SLOT_W      = ADDR_W + SIZE_W + STAMP_W;

  localparam logic [12:0] BEST_LIMIT = 13'd5000;
  localparam logic [12:0] PAGE_SLOT  = 13'd4080;
  localparam logic [12:0] HDR_BYTES  = 13'd16;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_PAGES = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic              operation;
    logic [SIZE_W-1:0] alloc_size;
    logic [ADDR_W-1:0] block_address;
  } bfa_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] object_address;
    logic              page_taken;
    logic [1:0]        status;
  } bfa_out_t;

  // one slot table row
  typedef struct packed {
    logic [ADDR_W-1:0]  hdr;
    logic [SIZE_W-1:0]  size;
    logic [STAMP_W-1:0] stamp;
  } bfa_slot_t;

  // scan control and result between sequencer and compare unit
  typedef struct packed {
    logic               start;
    logic               rd_ok;
    logic [12:0]        req;
    logic [STAMP_W-1:0] counter;
  } bfa_scan_ctl_t;

  typedef struct packed {
    logic               found;
    logic [SLOT_AW-1:0] best;
    logic               have_empty;
    logic [SLOT_AW-1:0] empty;
  } bfa_scan_res_t;

endpackage

// ===== rtl/bfa_ram.sv =====
module bfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bfa_scan.sv =====
module bfa_scan import bfa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  bfa_scan_ctl_t      ctl,
  input  logic [SLOT_AW-1:0] idx,
  input  logic               valid_bit,
  input  bfa_slot_t          row,
  output bfa_scan_res_t      res
);

  logic               found_r, found_nxt;
  logic [SLOT_AW-1:0] best_r, best_nxt;
  logic [12:0]        bsize_r, bsize_nxt;
  logic [STAMP_W-1:0] bage_r, bage_nxt;
  logic               hemp_r, hemp_nxt;
  logic [SLOT_AW-1:0] emp_r, emp_nxt;
  logic [STAMP_W-1:0] age;
  logic [12:0]        s;
  logic               fit;

  always_comb begin
    s   = {1'b0, row.size};
    age = ctl.counter - row.stamp;
    fit = valid_bit && s >= ctl.req && s < BEST_LIMIT;
    found_nxt = found_r;
    best_nxt  = best_r;
    bsize_nxt = bsize_r;
    bage_nxt  = bage_r;
    hemp_nxt  = hemp_r;
    emp_nxt   = emp_r;
    if (ctl.start) begin
      found_nxt = 1'b0;
      hemp_nxt  = 1'b0;
    end else if (ctl.rd_ok) begin
      if (fit && (!found_r || s < bsize_r || (s == bsize_r && age < bage_r))) begin
        found_nxt = 1'b1;
        best_nxt  = idx;
        bsize_nxt = s;
        bage_nxt  = age;
      end
      if (!valid_bit && !hemp_r) begin
        hemp_nxt = 1'b1;
        emp_nxt  = idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      hemp_r  <= 1'b0;
    end else begin
      found_r <= found_nxt;
      hemp_r  <= hemp_nxt;
    end
    best_r  <= best_nxt;
    bsize_r <= bsize_nxt;
    bage_r  <= bage_nxt;
    emp_r   <= emp_nxt;
  end

  assign res = '{found: found_r, best: best_r, have_empty: hemp_r, empty: emp_r};

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> !found_r && !hemp_r) else $error("scan not cleared");
  a_found_stays: assert property (@(posedge clk) disable iff (!rst_n)
    found_r && !ctl.start |=> found_r) else $error("best fit lost");
  a_empty_first: assert property (@(posedge clk) disable iff (!rst_n)
    hemp_r && !ctl.start |=> $stable(emp_r)) else $error("empty slot moved");

endmodule

// ===== rtl/best_fit_block_allocator.sv =====
// Best-fit block allocator. Each request (allocate or free) gets one result.
// An allocate sweeps the whole slot table through one compare unit, one slot
// per cycle; a free sweeps the table the same way to find its empty entry.
// After the sweep a pick step fetches the winning row and a further step
// updates the table and issues the result. A free with a bad address or a
// full table is answered from the pick step, and an oversized allocate is
// answered on the cycle after acceptance. The block is busy for the whole
// request and holds the result in an output register; in_ready rises on the
// cycle after the result is taken, so a new request is accepted only once
// the previous result has been taken; stalls on out_ready delay the next one.
// The slot table and block-size store are RAMs with registered read. Slot
// valid bits live in flip-flops and clear at reset; there is no clearing pass.
module best_fit_block_allocator import bfa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  bfa_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output bfa_out_t out_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_PICK  = 3'd2;
  localparam logic [2:0] S_ROW   = 3'd3;
  localparam logic [2:0] S_STORE = 3'd4;

  logic [2:0]         state_r, state_nxt;
  bfa_in_t            req_r;
  logic [12:0]        rsz_r, rsz_nxt;
  logic [SLOT_AW:0]   cnt_r, cnt_nxt;
  logic               rdv_r;        // slot RAM data valid for index rdi_r
  logic [SLOT_AW-1:0] rdi_r;
  logic [FREE_SLOTS-1:0] valid_r;
  logic [STAMP_W-1:0] ictr_r;
  logic [PAGE_CW-1:0] pages_r;
  logic               ov_r;
  bfa_out_t           od_r;

  // slot RAM port signals
  logic               s_we;
  logic [SLOT_AW-1:0] s_wa, s_ra;
  bfa_slot_t          s_wd, s_rd;
  // size store port signals
  logic               b_we;
  logic [STORE_AW-1:0] b_wa, b_ra;
  logic [SIZE_W-1:0]  b_wd, b_rd;

  bfa_scan_ctl_t ctl;
  bfa_scan_res_t res;

  bfa_ram #(.WIDTH(SLOT_W), .DEPTH(FREE_SLOTS)) u_slots (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd)
  );

  bfa_ram #(.WIDTH(SIZE_W), .DEPTH(STORE_DEPTH)) u_sizes (
    .clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd)
  );

  bfa_scan u_scan (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .idx(rdi_r),
    .valid_bit(valid_r[rdi_r]), .row(s_rd), .res(res)
  );

  assign in_ready  = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  // rounded request, 0 counts as 8
  logic [12:0] rnd;
  always_comb begin
    rnd = ({1'b0, in_data.alloc_size} + 13'd7) & ~13'd7;
    if (rnd == 13'd0) rnd = 13'd8;
  end

  logic [ADDR_W-1:0] page_hdr, free_hdr, hdr;
  logic [12:0]       have, rem;
  logic [ADDR_W:0]   claimed;
  logic              bad_free;
  assign page_hdr = ADDR_W'({pages_r, 12'd0});
  assign free_hdr = req_r.block_address - ADDR_W'(HDR_BYTES);
  assign claimed  = (ADDR_W+1)'({pages_r, 12'd0});
  assign bad_free = req_r.block_address < ADDR_W'(HDR_BYTES) ||
                    req_r.block_address[2:0] != 3'd0 ||
                    {1'b0, free_hdr} >= claimed;
  assign hdr  = res.found ? s_rd.hdr : page_hdr;
  assign have = res.found ? {1'b0, s_rd.size} : PAGE_SLOT;
  assign rem  = have - rsz_r;

  always_comb begin
    ctl.start   = in_valid && in_ready;
    ctl.rd_ok   = rdv_r;
    ctl.req     = rsz_r;
    ctl.counter = ictr_r;
  end

  logic              fin;
  bfa_out_t          fin_d;
  logic              put;
  logic [SLOT_AW-1:0] put_idx;
  logic              clr;

  always_comb begin
    state_nxt = state_r;
    rsz_nxt   = rsz_r;
    cnt_nxt   = cnt_r;
    s_ra      = cnt_r[SLOT_AW-1:0];
    s_we = 1'b0; s_wa = res.empty; s_wd = '0;
    b_we = 1'b0; b_wa = hdr[3 +: STORE_AW]; b_wd = rsz_r[SIZE_W-1:0];
    b_ra = free_hdr[3 +: STORE_AW];
    fin = 1'b0; fin_d = '{object_address: '0, page_taken: 1'b0, status: ST_OK};
    put = 1'b0; put_idx = res.empty; clr = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          rsz_nxt = rnd;
          cnt_nxt = '0;
          if (in_data.operation == OP_ALLOC && rnd > PAGE_SLOT) begin
            fin = 1'b1;
            fin_d.status = ST_NO_PAGES;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // advance one slot per cycle
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (SLOT_AW+1)'(FREE_SLOTS)) state_nxt = S_PICK;
      end
      S_PICK: begin
        // let the last compare land, then fetch the winner row
        s_ra = res.best;
        if (req_r.operation == OP_FREE) begin
          if (bad_free) begin
            fin = 1'b1; state_nxt = S_IDLE;
          end else if (!res.have_empty) begin
            fin = 1'b1; fin_d.status = ST_FULL; state_nxt = S_IDLE;
          end else begin
            state_nxt = S_STORE;
          end
        end else begin
          state_nxt = S_ROW;
        end
      end
      S_ROW: begin
        if (res.found) begin
          clr = 1'b1;
          b_we = 1'b1;
          fin = 1'b1;
          fin_d.object_address = hdr + ADDR_W'(HDR_BYTES);
          put_idx = res.best;
          put = rem > HDR_BYTES;
        end else if ({1'b0, pages_r} >= (PAGE_CW+1)'(HEAP_PAGES)) begin
          fin = 1'b1; fin_d.status = ST_NO_PAGES;
        end else if (rem > HDR_BYTES && !res.have_empty) begin
          fin = 1'b1; fin_d.status = ST_FULL;
        end else begin
          b_we = 1'b1;
          fin = 1'b1;
          fin_d.object_address = hdr + ADDR_W'(HDR_BYTES);
          fin_d.page_taken = 1'b1;
          put = rem > HDR_BYTES;
        end
        s_we = put;
        s_wa = put_idx;
        s_wd = '{hdr: hdr + ADDR_W'(HDR_BYTES) + ADDR_W'(rsz_r),
                 size: SIZE_W'(rem - HDR_BYTES), stamp: ictr_r};
        state_nxt = S_IDLE;
      end
      S_STORE: begin
        // size store read lands now; insert freed block
        put = 1'b1;
        s_we = 1'b1;
        s_wa = res.empty;
        s_wd = '{hdr: free_hdr, size: b_rd, stamp: ictr_r};
        fin = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  logic page_claim;
  assign page_claim = fin && fin_d.page_taken;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      ictr_r  <= '0;
      pages_r <= '0;
      ov_r    <= 1'b0;
      rdv_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rdv_r   <= (state_r == S_SCAN) && (cnt_r < (SLOT_AW+1)'(FREE_SLOTS));
      // a split reuses the winner's entry, so a put covers the clear
      if (put) begin
        valid_r[put_idx] <= 1'b1;
        ictr_r <= ictr_r + 1'b1;
      end else if (clr) begin
        valid_r[res.best] <= 1'b0;
      end
      if (page_claim) pages_r <= pages_r + 1'b1;
      if (fin) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
    rdi_r <= cnt_r[SLOT_AW-1:0];
    rsz_r <= rsz_nxt;
    cnt_r <= cnt_nxt;
    if (in_valid && in_ready) req_r <= in_data;
    if (fin) od_r <= fin_d;
  end

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ready) else $error("ready while busy");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    fin |-> !ov_r) else $error("result overwritten");
  a_pages_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, pages_r} <= (PAGE_CW+1)'(HEAP_PAGES)) else $error("page overrun");
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.object_address == '0)
    else $error("error with address");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import bfa_pkg::*;

  localparam int QUIET_LIMIT = 20000;  // cycles with no request or reply moving
  localparam int DRAIN_CYCLES = 300;   // about one full table sweep

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  bfa_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  bfa_out_t out_data;

  best_fit_block_allocator u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow heap: slot table, page count and per-block size store
  logic [ADDR_W-1:0]  sl_hdr   [FREE_SLOTS];
  logic [SIZE_W-1:0]  sl_size  [FREE_SLOTS];
  bit                 sl_valid [FREE_SLOTS];
  logic [STAMP_W-1:0] sl_stamp [FREE_SLOTS];
  logic [STAMP_W-1:0] ins_cnt;
  int                 pages;
  logic [SIZE_W-1:0]  blk_size [STORE_DEPTH];

  bfa_out_t          pending_replies[$];
  logic [ADDR_W-1:0] live_objs[$];   // allocated and not yet freed
  logic [ADDR_W-1:0] freed_objs[$];  // freed once, fair game for a double free
  bfa_out_t          last_reply;

  bit no_idle = 1'b0;
  int mismatches = 0;
  int n_req = 0, n_alloc = 0, n_free = 0, n_full = 0, n_nopage = 0, n_fresh = 0;
  int quiet = 0;
  int out_hold = 0;

  function automatic int find_empty();
    for (int i = 0; i < FREE_SLOTS; i++)
      if (!sl_valid[i]) return i;
    return -1;
  endfunction

  function automatic void put_slot(int i, int hdr, int size);
    sl_hdr[i]   = hdr[ADDR_W-1:0];
    sl_size[i]  = size[SIZE_W-1:0];
    sl_valid[i] = 1'b1;
    sl_stamp[i] = ins_cnt;
    ins_cnt     = ins_cnt + 1;
  endfunction

  // Best fit over valid slots; newest slot wins a tie, else carve a fresh page
  function automatic bfa_out_t book_alloc(logic [SIZE_W-1:0] raw);
    bfa_out_t r;
    int req, best, win_size, hdr, have, entry, rem;
    logic [STAMP_W-1:0] age, best_age;
    bit fresh;
    r = '0;
    req = (int'(raw) + 7) & ~7;
    if (req == 0) req = 8;
    if (req > int'(PAGE_SLOT)) begin
      r.status = ST_NO_PAGES;
      return r;
    end
    best = -1; win_size = int'(BEST_LIMIT); best_age = '0; fresh = 0;
    for (int i = 0; i < FREE_SLOTS; i++) begin
      age = ins_cnt - sl_stamp[i];
      if (!sl_valid[i] || int'(sl_size[i]) < req || int'(sl_size[i]) >= int'(BEST_LIMIT))
        continue;
      if (best < 0 || int'(sl_size[i]) < win_size ||
          (int'(sl_size[i]) == win_size && age < best_age)) begin
        best = i; win_size = int'(sl_size[i]); best_age = age;
      end
    end
    if (best >= 0) begin
      hdr = int'(sl_hdr[best]); have = win_size;
      sl_valid[best] = 1'b0; entry = best;
    end else begin
      if (pages >= HEAP_PAGES) begin
        r.status = ST_NO_PAGES;
        return r;
      end
      hdr = pages * 4096; have = int'(PAGE_SLOT);
      entry = find_empty();
      if (have - req > int'(HDR_BYTES) && entry < 0) begin
        r.status = ST_FULL;
        return r;
      end
      pages++; fresh = 1;
    end
    rem = have - req;
    blk_size[hdr >> 3] = req[SIZE_W-1:0];
    if (rem > int'(HDR_BYTES) && entry >= 0)
      put_slot(entry, hdr + int'(HDR_BYTES) + req, rem - int'(HDR_BYTES));
    r.object_address = ADDR_W'(hdr + int'(HDR_BYTES));
    r.page_taken = fresh;
    r.status = ST_OK;
    return r;
  endfunction

  // Reinsert the block with its stored size; bad addresses are ignored
  function automatic bfa_out_t book_free(logic [ADDR_W-1:0] addr);
    bfa_out_t r;
    int hdr, entry;
    r = '0;
    if (addr < ADDR_W'(HDR_BYTES) || addr[2:0] != 3'd0) return r;
    hdr = int'(addr) - int'(HDR_BYTES);
    if (hdr >= pages * 4096) return r;
    entry = find_empty();
    if (entry < 0) begin
      r.status = ST_FULL;
      return r;
    end
    put_slot(entry, hdr, int'(blk_size[hdr >> 3]));
    return r;
  endfunction

  // Drive one request at the falling edge, hold it until accepted, then book it
  task automatic send_req(logic op, logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] addr);
    bfa_in_t d;
    int gap;
    d.operation = op; d.alloc_size = sz; d.block_address = addr;
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (!in_ready);
    last_reply = (op == OP_ALLOC) ? book_alloc(sz) : book_free(addr);
    pending_replies.push_back(last_reply);
    n_req++;
    if (op == OP_ALLOC) begin
      n_alloc++;
      if (last_reply.status == ST_OK) live_objs.push_back(last_reply.object_address);
    end else begin
      n_free++;
    end
    if (last_reply.status == ST_FULL) n_full++;
    if (last_reply.status == ST_NO_PAGES) n_nopage++;
    if (last_reply.page_taken) n_fresh++;
  endtask

  task automatic do_alloc(logic [SIZE_W-1:0] sz);
    send_req(OP_ALLOC, sz, ADDR_W'($urandom));
  endtask

  task automatic do_free(logic [ADDR_W-1:0] addr);
    send_req(OP_FREE, SIZE_W'($urandom), addr);
  endtask

  // Free the live object at index idx and remember it for double frees
  task automatic free_live(int idx);
    logic [ADDR_W-1:0] a;
    a = live_objs[idx];
    live_objs.delete(idx);
    freed_objs.push_back(a);
    do_free(a);
  endtask

  // Mostly frees of live objects; a few double frees and malformed addresses
  task automatic random_free();
    int r, lo;
    r = $urandom_range(0, 99);
    if (live_objs.size() > 0 && r < 85) begin
      free_live($urandom_range(0, live_objs.size() - 1));
    end else if (freed_objs.size() > 0 && r < 90) begin
      do_free(freed_objs[$urandom_range(0, freed_objs.size() - 1)]);
    end else if (r < 94) begin
      do_free(ADDR_W'($urandom_range(0, 15)));
    end else if (r < 97 || pages >= HEAP_PAGES) begin
      do_free(ADDR_W'($urandom) | 18'd1);
    end else begin
      // header past the last claimed page
      lo = pages * 4096 + 16;
      do_free(ADDR_W'(lo + 8 * $urandom_range(0, (262136 - lo) / 8)));
    end
  endtask

  // Small sizes dominate so that pages last; odd, zero and oversized sizes too
  function automatic logic [SIZE_W-1:0] random_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return SIZE_W'(8 * $urandom_range(1, 32));
    if (r < 80) return SIZE_W'($urandom_range(0, 300));
    if (r < 95) return SIZE_W'($urandom_range(0, 4000));
    return SIZE_W'($urandom_range(0, 4095));
  endfunction

  task automatic random_mix(int count);
    for (int k = 0; k < count; k++)
      if ($urandom_range(0, 99) < 58) do_alloc(random_size());
      else random_free();
  endtask

  // Directed: size rounding, oversize, malformed frees, tie on equal sizes
  task automatic test_directed();
    logic [ADDR_W-1:0] a, b;
    do_alloc(12'd0);
    do_alloc(12'd1);
    do_alloc(12'd7);
    do_alloc(12'd8);
    do_alloc(12'd4081);
    do_alloc(12'd4088);
    do_alloc(12'd4095);
    do_alloc(12'd4080);     // whole page, no remainder slot
    do_alloc(12'd4064);     // remainder of exactly 16 is lost
    do_alloc(12'd4000);
    do_free(18'd0);
    do_free(18'd8);
    do_free(18'd17);
    do_free(18'h3FFFF);
    do_free(18'd262136);    // beyond the claimed pages
    do_alloc(12'd40);
    a = last_reply.object_address;
    do_alloc(12'd40);
    b = last_reply.object_address;
    live_objs.delete(live_objs.size() - 1);
    live_objs.delete(live_objs.size() - 1);
    do_free(a);
    do_free(b);             // same size as a, newer, so it is picked first
    do_alloc(12'd40);
    do_free(a);             // double free
    freed_objs.push_back(a);
    freed_objs.push_back(b);
    do_alloc(12'd33);
  endtask

  // Flood the table with tiny freed blocks until it overflows
  task automatic test_table_full();
    for (int k = 0; k < 300; k++) do_alloc(12'd8);
    while (live_objs.size() > 0) free_live(live_objs.size() - 1);
    do_alloc(12'd2000);
    do_alloc(12'd4000);
    do_alloc(12'd16);
    do_alloc(12'd8);
    do_free(freed_objs[0]);
  endtask

  task automatic test_random();
    random_mix(550);
  endtask

  // Claim pages until none are left or the guard runs out, then ask twice more
  task automatic test_exhaust();
    int guard;
    guard = 0;
    while (pages < HEAP_PAGES && guard < 200) begin
      do_alloc(12'd4080);
      guard++;
    end
    do_alloc(12'd4080);
    do_alloc(12'd4000);
    random_free();
  endtask

  task automatic test_tail();
    no_idle = 1'b1;
    random_mix(250);
  endtask

  // Receiver stalls in random bursts; none at the tail
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold  <= out_hold - 1;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      out_hold  <= $urandom_range(0, 12);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare every accepted reply with the oldest outstanding prediction
  always @(posedge clk) begin
    bfa_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected reply addr=%0d page=%0d st=%0d",
                   out_data.object_address, out_data.page_taken, out_data.status);
      end else begin
        want = pending_replies.pop_front();
        if (out_data.object_address !== want.object_address ||
            out_data.page_taken !== want.page_taken || out_data.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("reply mismatch: exp addr=%0d page=%0d st=%0d, got addr=%0d page=%0d st=%0d",
                     want.object_address, want.page_taken, want.status,
                     out_data.object_address, out_data.page_taken, out_data.status);
        end
      end
    end
  end

  // Watchdog: the run must keep moving requests or replies
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    for (int i = 0; i < FREE_SLOTS; i++) begin
      sl_valid[i] = 1'b0; sl_hdr[i] = '0; sl_size[i] = '0; sl_stamp[i] = '0;
    end
    ins_cnt = '0;
    pages = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_table_full();
    test_random();
    test_exhaust();
    test_tail();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_replies.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_replies.size() > 0) mismatches++;

    $display("%0d requests: %0d allocs, %0d frees, %0d fresh pages, %0d pages used",
             n_req, n_alloc, n_free, n_fresh, pages);
    $display("%0d table-full replies, %0d out-of-heap replies, %0d mismatches",
             n_full, n_nopage, mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
